FILE: sv/tpc_pkg.sv
// Shared types and constants of the three-prime CRT reconstruction unit.
// No dependencies; every other file in sv/ but tpc_barrett refers to it by scoped names.
package tpc_pkg;

    // NTT primes, each at the width of its residue field
    localparam logic [27:0] PRIME0 = 28'd167772161;
    localparam logic [28:0] PRIME1 = 29'd469762049;
    localparam logic [29:0] PRIME2 = 30'd754974721;

    localparam logic [30:0] MODULUS_RESET = 31'd998244353;
    localparam logic [30:0] MODULUS_MIN   = 31'd2;

    // a*b mod p by double-and-add, for elaboration-time constants only
    function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] p);
        logic [63:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = r << 1;
            if (r >= p)
                r = r - p;
            if (y[i])
            begin
                r = r + x;
                if (r >= p)
                    r = r - p;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] pow_mod(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] p);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 63; i >= 0; i--)
        begin
            r = mul_mod(r, r, p);
            if (e[i])
                r = mul_mod(r, b, p);
        end
        return r;
    endfunction

    // Fermat inverses between the primes
    localparam logic [63:0] INV01_W = pow_mod(64'(PRIME0), 64'(PRIME1) - 64'd2, 64'(PRIME1));
    localparam logic [63:0] INV02_W = pow_mod(64'(PRIME0), 64'(PRIME2) - 64'd2, 64'(PRIME2));
    localparam logic [63:0] INV12_W = pow_mod(64'(PRIME1), 64'(PRIME2) - 64'd2, 64'(PRIME2));
    localparam logic [63:0] INV0212_W = mul_mod(INV02_W, INV12_W, 64'(PRIME2));

    localparam logic [28:0] INV01   = INV01_W[28:0];
    localparam logic [29:0] INV12   = INV12_W[29:0];
    localparam logic [29:0] INV0212 = INV0212_W[29:0];

    // Barrett reciprocals floor(2^62 / p)
    localparam logic [61:0] MU_P1    = 62'((64'd1 << 62) / 64'(PRIME1));
    localparam logic [61:0] MU_P2    = 62'((64'd1 << 62) / 64'(PRIME2));
    localparam logic [61:0] MU_RESET = 62'((64'd1 << 62) / 64'(MODULUS_RESET));

    // Weights for the reset modulus
    localparam logic [30:0] W1_RESET = 31'(64'(PRIME0) % 64'(MODULUS_RESET));
    localparam logic [30:0] W2_RESET =
        31'((64'(PRIME0) * 64'(PRIME1)) % 64'(MODULUS_RESET));

    // Derived configuration seen by the datapath
    typedef struct packed {
        logic [30:0] modulus;
        logic [61:0] mu;
        logic [30:0] w1;
        logic [30:0] w2;
        logic        mod_trivial;
    } cfg_t;

endpackage

FILE: sv/tpc_barrett.sv
// Six-stage Barrett reducer: x (62 bits) mod a 31-bit modulus, given floor(2^62/m).
// Depends on nothing outside itself; side data rides along with each item.
module tpc_barrett #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [61:0]       x,
    input  logic [61:0]       mu,
    input  logic [30:0]       modulus,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [30:0]       r,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NS = 6;

    logic [NS-1:0]     vld_reg;
    logic [NS-1:0]     en;
    logic [SIDE_W-1:0] side_reg [NS];

    logic [61:0] pp_ll_reg, pp_hl_reg, pp_lh_reg, pp_hh_reg;
    logic [62:0] s1_reg;
    logic [61:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic [61:0] q_reg;
    logic [61:0] qlm_reg, qhm_reg;
    logic [31:0] r5_reg;
    logic [30:0] r_reg;

    logic [63:0] s_full;
    logic [32:0] r33;
    logic [31:0] r6_diff;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign s_full  = 64'(s1_reg) + 64'(pp_lh_reg);
    assign r33     = x4_reg[32:0] - qlm_reg[32:0] - {qhm_reg[1:0], 31'd0};
    assign r6_diff = r5_reg - {1'b0, modulus};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pp_ll_reg   <= 62'(x[30:0]) * 62'(mu[30:0]);
            pp_hl_reg   <= 62'(x[61:31]) * 62'(mu[30:0]);
            x1_reg      <= x;
            side_reg[0] <= side_in;
        end
        if (en[1])
        begin
            pp_lh_reg   <= 62'(x1_reg[30:0]) * 62'(mu[61:31]);
            pp_hh_reg   <= 62'(x1_reg[61:31]) * 62'(mu[61:31]);
            s1_reg      <= 63'(pp_ll_reg[61:31]) + 63'(pp_hl_reg);
            x2_reg      <= x1_reg;
            side_reg[1] <= side_reg[0];
        end
        if (en[2])
        begin
            q_reg       <= 62'(pp_hh_reg + 62'(s_full[63:31]));
            x3_reg      <= x2_reg;
            side_reg[2] <= side_reg[1];
        end
        if (en[3])
        begin
            qlm_reg     <= 62'(q_reg[30:0]) * 62'(modulus);
            qhm_reg     <= 62'(q_reg[61:31]) * 62'(modulus);
            x4_reg      <= x3_reg;
            side_reg[3] <= side_reg[2];
        end
        if (en[4])
        begin
            r5_reg      <= r33[31:0];
            side_reg[4] <= side_reg[3];
        end
        if (en[5])
        begin
            r_reg       <= (r5_reg >= {1'b0, modulus}) ? r6_diff[30:0] : r5_reg[30:0];
            side_reg[5] <= side_reg[4];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NS-1];
    assign r         = r_reg;
    assign side_out  = side_reg[NS-1];

endmodule

FILE: sv/tpc_front.sv
// Front stages: residue correction, Garner differences and the first products.
// Depends on tpc_pkg for the primes and inverses.
module tpc_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [27:0] residue_p0,
    input  logic [28:0] residue_p1,
    input  logic [29:0] residue_p2,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [61:0] x_b,
    output logic [27:0] a_out,
    output logic [59:0] prod_c1
);

    localparam int NS = 3;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic [27:0] a0_reg, a1_reg, a2_reg;
    logic [28:0] n1_reg;
    logic [29:0] n2_reg;
    logic [29:0] t1_reg;
    logic [29:0] d2_reg;
    logic [58:0] pb_reg;
    logic [59:0] pc1_reg;

    logic [30:0] d2_sum;
    logic [30:0] d2_red;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign d2_sum = 31'(n2_reg) + 31'(tpc_pkg::PRIME2) - 31'(a0_reg);
    assign d2_red = d2_sum - 31'(tpc_pkg::PRIME2);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            // fold residues that are not below their prime
            a0_reg <= (residue_p0 >= tpc_pkg::PRIME0) ? residue_p0 - tpc_pkg::PRIME0
                                                      : residue_p0;
            n1_reg <= (residue_p1 >= tpc_pkg::PRIME1) ? residue_p1 - tpc_pkg::PRIME1
                                                      : residue_p1;
            n2_reg <= (residue_p2 >= tpc_pkg::PRIME2) ? residue_p2 - tpc_pkg::PRIME2
                                                      : residue_p2;
        end
        if (en[1])
        begin
            t1_reg <= 30'(n1_reg) + 30'(tpc_pkg::PRIME1) - 30'(a0_reg);
            d2_reg <= (d2_sum >= 31'(tpc_pkg::PRIME2)) ? d2_red[29:0] : d2_sum[29:0];
            a1_reg <= a0_reg;
        end
        if (en[2])
        begin
            pb_reg  <= 59'(t1_reg) * 59'(tpc_pkg::INV01);
            pc1_reg <= 60'(d2_reg) * 60'(tpc_pkg::INV0212);
            a2_reg  <= a1_reg;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NS-1];
    assign x_b       = 62'(pb_reg);
    assign a_out     = a2_reg;
    assign prod_c1   = pc1_reg;

endmodule

FILE: sv/tpc_mid.sv
// Middle stages: second product of digit c and the sum fed to the mod-P2 reducer.
// Depends on tpc_pkg for PRIME2 and the inverse of P1.
module tpc_mid (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [28:0] b_in,
    input  logic [27:0] a_in,
    input  logic [59:0] prod_c1,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [61:0] x_c,
    output logic [27:0] a_out,
    output logic [28:0] b_out
);

    localparam int NS = 2;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic [59:0] pc2_reg, pc1_reg;
    logic [27:0] a0_reg, a1_reg;
    logic [28:0] b0_reg, b1_reg;
    logic [60:0] xc_reg;

    logic [29:0] neg_b;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign neg_b = tpc_pkg::PRIME2 - 30'(b_in);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pc2_reg <= 60'(neg_b) * 60'(tpc_pkg::INV12);
            pc1_reg <= prod_c1;
            a0_reg  <= a_in;
            b0_reg  <= b_in;
        end
        if (en[1])
        begin
            xc_reg <= 61'(pc1_reg) + 61'(pc2_reg);
            a1_reg <= a0_reg;
            b1_reg <= b0_reg;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NS-1];
    assign x_c       = 62'(xc_reg);
    assign a_out     = a1_reg;
    assign b_out     = b1_reg;

endmodule

FILE: sv/tpc_back.sv
// Back stages: weight the mixed-radix digits and sum them for the final reduction.
// Depends on tpc_pkg for the configuration struct.
module tpc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [27:0]    a_in,
    input  logic [28:0]    b_in,
    input  logic [29:0]    c_in,
    input  tpc_pkg::cfg_t  cfg,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [61:0]    x_m,
    output logic           mod_trivial
);

    localparam int NS = 2;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic [59:0] p1_reg;
    logic [60:0] p2_reg;
    logic [27:0] a_reg;
    logic        small0_reg, small1_reg;
    logic [61:0] x_reg;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1_reg     <= 60'(b_in) * 60'(cfg.w1);
            p2_reg     <= 61'(c_in) * 61'(cfg.w2);
            a_reg      <= a_in;
            small0_reg <= cfg.mod_trivial;
        end
        if (en[1])
        begin
            x_reg      <= 62'(a_reg) + 62'(p1_reg) + 62'(p2_reg);
            small1_reg <= small0_reg;
        end
    end

    assign in_stall    = !en[0];
    assign out_valid   = vld_reg[NS-1];
    assign x_m         = x_reg;
    assign mod_trivial = small1_reg;

endmodule

FILE: sv/tpc_cfg.sv
// Target modulus register and the bit-serial divider that derives mu, w1 and w2.
// Depends on tpc_pkg for the primes, reset values and cfg_t.
module tpc_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [30:0]   cfg_data,
    output tpc_pkg::cfg_t cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MU,
        ST_W1,
        ST_LOAD_W2,
        ST_W2
    } state_t;

    state_t      state_reg;
    logic [30:0] modulus_reg;
    logic [61:0] mu_reg;
    logic [30:0] w1_reg, w2_reg;
    logic [63:0] dvd_reg;
    logic [30:0] rem_reg;
    logic [61:0] quo_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] rem_shift;
    logic [31:0] rem_diff;
    logic        sub_ok;
    logic [30:0] rem_next;
    logic [61:0] quo_next;

    // one restoring-division step per cycle
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[63]};
        rem_diff  = rem_shift - {1'b0, modulus_reg};
        sub_ok    = rem_shift >= {1'b0, modulus_reg};
        rem_next  = sub_ok ? rem_diff[30:0] : rem_shift[30:0];
        quo_next  = {quo_reg[60:0], sub_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            modulus_reg <= tpc_pkg::MODULUS_RESET;
            mu_reg      <= tpc_pkg::MU_RESET;
            w1_reg      <= tpc_pkg::W1_RESET;
            w2_reg      <= tpc_pkg::W2_RESET;
            dvd_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        modulus_reg <= cfg_data;
                        if (cfg_data >= tpc_pkg::MODULUS_MIN)
                        begin
                            state_reg <= ST_MU;
                            dvd_reg   <= 64'd1 << 62;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                        end
                    end
                end
                ST_MU:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (&cnt_reg)
                    begin
                        mu_reg    <= quo_next;
                        dvd_reg   <= 64'(tpc_pkg::PRIME0);
                        rem_reg   <= '0;
                        state_reg <= ST_W1;
                    end
                end
                ST_W1:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (&cnt_reg)
                    begin
                        w1_reg    <= rem_next;
                        state_reg <= ST_LOAD_W2;
                    end
                end
                ST_LOAD_W2:
                begin
                    dvd_reg   <= 64'(60'(w1_reg) * 60'(tpc_pkg::PRIME1));
                    rem_reg   <= '0;
                    state_reg <= ST_W2;
                end
                ST_W2:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (&cnt_reg)
                    begin
                        w2_reg    <= rem_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready       = (state_reg == ST_IDLE);
    assign cfg.modulus     = modulus_reg;
    assign cfg.mu          = mu_reg;
    assign cfg.w1          = w1_reg;
    assign cfg.w2          = w2_reg;
    assign cfg.mod_trivial = modulus_reg < tpc_pkg::MODULUS_MIN;

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_data >= tpc_pkg::MODULUS_MIN) |=> state_reg == ST_MU)
        else $error("derivation did not start after a modulus write");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |=> $stable(modulus_reg))
        else $error("modulus changed during derivation");

    a_weights: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready && (modulus_reg >= tpc_pkg::MODULUS_MIN)
        |-> (w1_reg < modulus_reg) && (w2_reg < modulus_reg))
        else $error("weights not reduced below the modulus");

endmodule

FILE: sv/three_prime_crt_reconstruct_unit.sv
// Top level of the three-prime CRT reconstruction unit.
// Depends on tpc_pkg, tpc_cfg, tpc_front, tpc_barrett, tpc_mid and tpc_back.
//
// Usage
//   Input channel (in_valid / in_stall) takes one item per cycle while in_stall is low:
//   the residues of a convolution coefficient modulo 167772161, 469762049 and 754974721.
//   Output channel (out_valid / out_stall) returns the rebuilt coefficient
//   reduced modulo target_modulus, one item per input item, in order.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the target
//   modulus; write it only while no item is in flight.
// Pipeline and throughput
//   One item per cycle sustained while out_stall stays low. The pipeline is
//   built from three six-stage Barrett reducers (mod P1, mod P2, mod target) plus
//   seven stages of residue correction and digit products.
//   A modulus write of 2 or more starts a bit-serial derivation of floor(2^62/m),
//   P0 mod m and P0*P1 mod m, during which cfg_ready is low and in_stall is
//   high. A modulus below 2 gives coefficient 0 and needs no derivation.
// Reset
//   Clears all valid bits and loads modulus 998244353 with its weights ready.
// Stall
//   Each stage holds only while it is full and the stage after it holds, so
//   bubbles drain and the input keeps flowing until the pipe is full.
module three_prime_crt_reconstruct_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [27:0] residue_p0,
    input  logic [28:0] residue_p1,
    input  logic [29:0] residue_p2,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] coefficient,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    tpc_pkg::cfg_t cfg;

    // front -> mod P1 reducer
    logic        fr_in_stall;
    logic        fr_valid, fr_stall;
    logic [61:0] fr_x_b;
    logic [27:0] fr_a;
    logic [59:0] fr_pc1;

    // mod P1 reducer -> mid
    logic        rb_valid, rb_stall;
    logic [30:0] rb_r;
    logic [87:0] rb_side;

    // mid -> mod P2 reducer
    logic        md_valid, md_stall;
    logic [61:0] md_x_c;
    logic [27:0] md_a;
    logic [28:0] md_b;

    // mod P2 reducer -> back
    logic        rc_valid, rc_stall;
    logic [30:0] rc_r;
    logic [56:0] rc_side;

    // back -> target reducer
    logic        bk_valid, bk_stall;
    logic [61:0] bk_x;
    logic        bk_small;

    logic [30:0] rm_r;
    logic        rm_small;

    tpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // hold the input while the weights are being derived
    assign in_stall = fr_in_stall || !cfg_ready;

    tpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid && cfg_ready),
        .in_stall   (fr_in_stall),
        .residue_p0 (residue_p0),
        .residue_p1 (residue_p1),
        .residue_p2 (residue_p2),
        .out_valid  (fr_valid),
        .out_stall  (fr_stall),
        .x_b        (fr_x_b),
        .a_out      (fr_a),
        .prod_c1    (fr_pc1)
    );

    // digit b = x_b mod P1
    tpc_barrett #(.SIDE_W(88)) u_red_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .x         (fr_x_b),
        .mu        (tpc_pkg::MU_P1),
        .modulus   (31'(tpc_pkg::PRIME1)),
        .side_in   ({fr_a, fr_pc1}),
        .out_valid (rb_valid),
        .out_stall (rb_stall),
        .r         (rb_r),
        .side_out  (rb_side)
    );

    tpc_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rb_valid),
        .in_stall  (rb_stall),
        .b_in      (rb_r[28:0]),
        .a_in      (rb_side[87:60]),
        .prod_c1   (rb_side[59:0]),
        .out_valid (md_valid),
        .out_stall (md_stall),
        .x_c       (md_x_c),
        .a_out     (md_a),
        .b_out     (md_b)
    );

    // digit c = x_c mod P2
    tpc_barrett #(.SIDE_W(57)) u_red_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (md_valid),
        .in_stall  (md_stall),
        .x         (md_x_c),
        .mu        (tpc_pkg::MU_P2),
        .modulus   (31'(tpc_pkg::PRIME2)),
        .side_in   ({md_a, md_b}),
        .out_valid (rc_valid),
        .out_stall (rc_stall),
        .r         (rc_r),
        .side_out  (rc_side)
    );

    tpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rc_valid),
        .in_stall    (rc_stall),
        .a_in        (rc_side[56:29]),
        .b_in        (rc_side[28:0]),
        .c_in        (rc_r[29:0]),
        .cfg         (cfg),
        .out_valid   (bk_valid),
        .out_stall   (bk_stall),
        .x_m         (bk_x),
        .mod_trivial (bk_small)
    );

    // final reduction by the configured modulus
    tpc_barrett #(.SIDE_W(1)) u_red_m (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bk_valid),
        .in_stall  (bk_stall),
        .x         (bk_x),
        .mu        (cfg.mu),
        .modulus   (cfg.modulus),
        .side_in   (bk_small),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .r         (rm_r),
        .side_out  (rm_small)
    );

    // a modulus of zero or one yields zero
    assign coefficient = rm_small ? 31'd0 : rm_r;

endmodule
